// File: hdl/iiea_pkg.sv
// ----------------------------------------------------------------------------
// iiea_pkg
// Types and codes shared by the indexed insert/erase array and its cells.
// ----------------------------------------------------------------------------
package iiea_pkg;

    typedef enum logic [2:0] {
        CMD_PUSH   = 3'd0,
        CMD_POP    = 3'd1,
        CMD_INSERT = 3'd2,
        CMD_ERASE  = 3'd3,
        CMD_READ   = 3'd4
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_WAIT = 2'd1,
        S_OUT  = 2'd2
    } t_state;

    // per-cell update controls
    typedef struct packed {
        logic wr_val;
        logic from_left;
        logic from_right;
        logic rd_load;
    } t_cell_ctl;

    localparam int unsigned IN_TDATA_W  = 48;
    localparam int unsigned OUT_TDATA_W = 48;

endpackage

// File: hdl/iiea_cell.sv
// ----------------------------------------------------------------------------
// iiea_cell
// One array slot: holds an entry, shifts to or from its neighbours and
// passes the read word down the chain one slot per cycle.
// ----------------------------------------------------------------------------
module iiea_cell #(
    parameter int unsigned DATA_WIDTH = 32
) (
    input  logic                     i_clk,
    input  iiea_pkg::t_cell_ctl      i_ctl,
    input  logic [DATA_WIDTH-1:0]    i_val,
    input  logic [DATA_WIDTH-1:0]    i_left,
    input  logic [DATA_WIDTH-1:0]    i_right,
    input  logic [DATA_WIDTH-1:0]    i_bus,
    output logic [DATA_WIDTH-1:0]    o_data,
    output logic [DATA_WIDTH-1:0]    o_bus
);
    import iiea_pkg::*;

    logic [DATA_WIDTH-1:0] r_data;
    logic [DATA_WIDTH-1:0] r_bus;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_val) begin
            r_data <= i_val;
        end else if (i_ctl.from_left) begin
            r_data <= i_left;
        end else if (i_ctl.from_right) begin
            r_data <= i_right;
        end
    end

    // read word travels towards slot zero
    always_ff @(posedge i_clk) begin
        if (i_ctl.rd_load) begin
            r_bus <= r_data;
        end else begin
            r_bus <= i_bus;
        end
    end

    assign o_data = r_data;
    assign o_bus  = r_bus;

endmodule

// File: hdl/indexed_insert_erase_array_core.sv
// ----------------------------------------------------------------------------
// indexed_insert_erase_array_core
// Fixed-capacity ordered array with push, pop, indexed insert, indexed erase
// and indexed read, built as a chain of slot cells.
// ----------------------------------------------------------------------------
// usage:
//   s_axis carries one command word (command, position, item_value); m_axis
//   returns one result word (read_value, count, status) per command.
//   push, pop, insert, erase and failed reads complete in the accept cycle,
//   any slot updates done in parallel; the result word is valid the next
//   cycle, and a new command is taken in the same cycle the result is
//   taken, so these run at one command per cycle while m_axis is ready.
//   a successful read hands the entry down the slot chain one slot per
//   cycle until it reaches slot zero, where the result is captured; the
//   next command is taken once that result is taken.
//   a stalled m_axis holds the result word and s_axis_tready stays low.
//   reset empties the array (count zero); slot contents are not cleared and
//   slots at or above the count are never read.
//   count carries the low 7 bits of the entry count.
// ----------------------------------------------------------------------------
module indexed_insert_erase_array_core #(
    parameter int unsigned DEPTH      = 64,
    parameter int unsigned DATA_WIDTH = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // command[2:0], position[9:3], item_value[41:10], zero pad
    input  logic [iiea_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // read_value[31:0], count[38:32], status[40:39], zero pad
    output logic [iiea_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);
    import iiea_pkg::*;

    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam int unsigned IW = $clog2(DEPTH);
    localparam int unsigned PW = (CW > 7) ? CW : 7;

    t_state                r_state, n_state;
    logic [CW-1:0]         r_count, n_count;
    logic [IW-1:0]         r_hop, n_hop;
    logic [31:0]           r_rd, n_rd;
    t_status               r_status, n_status;

    logic                  w_accept;
    logic                  w_out_take;
    logic                  w_read_ok;
    t_cmd                  w_cmd;
    logic [6:0]            w_pos_raw;
    logic [31:0]           w_item;
    logic [PW-1:0]         w_pos;
    logic [PW-1:0]         w_cnt;
    logic [DATA_WIDTH-1:0] w_val;
    logic [63:0]           w_item_wide;
    logic [63:0]           w_bus_ext;

    logic                  w_go_push, w_go_insert, w_go_erase;
    t_status               w_status;

    t_cell_ctl             w_ctl   [DEPTH];
    logic [DATA_WIDTH-1:0] w_data  [DEPTH];
    logic [DATA_WIDTH-1:0] w_bus   [DEPTH];

    assign w_cmd       = t_cmd'(s_axis_tdata[2:0]);
    assign w_pos_raw   = s_axis_tdata[9:3];
    assign w_item      = s_axis_tdata[41:10];
    assign w_pos       = PW'(w_pos_raw);
    assign w_cnt       = PW'(r_count);
    assign w_item_wide = {32'd0, w_item};
    assign w_val       = w_item_wide[DATA_WIDTH-1:0];
    assign w_bus_ext   = 64'(signed'(w_bus[0]));

    assign s_axis_tready = (r_state == S_IDLE) || ((r_state == S_OUT) && m_axis_tready);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_out_take    = m_axis_tvalid && m_axis_tready;

    // command decode
    always_comb begin
        w_status    = ST_OK;
        w_go_push   = 1'b0;
        w_go_insert = 1'b0;
        w_go_erase  = 1'b0;
        w_read_ok   = 1'b0;
        n_count     = r_count;
        case (w_cmd)
            CMD_PUSH: begin
                if (w_cnt >= PW'(DEPTH)) begin
                    w_status = ST_FULL;
                end else begin
                    w_go_push = 1'b1;
                    n_count   = r_count + CW'(1);
                end
            end
            CMD_POP: begin
                if (r_count == '0) begin
                    w_status = ST_RANGE;
                end else begin
                    n_count = r_count - CW'(1);
                end
            end
            CMD_INSERT: begin
                if (w_pos > w_cnt) begin
                    w_status = ST_RANGE;
                end else if (w_cnt >= PW'(DEPTH)) begin
                    w_status = ST_FULL;
                end else begin
                    w_go_insert = 1'b1;
                    n_count     = r_count + CW'(1);
                end
            end
            CMD_ERASE: begin
                if (w_pos >= w_cnt) begin
                    w_status = ST_RANGE;
                end else begin
                    w_go_erase = 1'b1;
                    n_count    = r_count - CW'(1);
                end
            end
            CMD_READ: begin
                if (w_pos >= w_cnt) begin
                    w_status = ST_RANGE;
                end else begin
                    w_read_ok = 1'b1;
                end
            end
            default: begin
                w_status = ST_OK;
            end
        endcase
    end

    // slot controls
    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            w_ctl[i].wr_val     = w_accept &&
                                  ((w_go_push && (PW'(i) == w_cnt)) ||
                                   (w_go_insert && (PW'(i) == w_pos)));
            w_ctl[i].from_left  = w_accept && w_go_insert && (PW'(i) > w_pos);
            w_ctl[i].from_right = w_accept && w_go_erase && (PW'(i) >= w_pos);
            w_ctl[i].rd_load    = w_accept && w_read_ok && (PW'(i) == w_pos);
        end
    end

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [DATA_WIDTH-1:0] w_left;
        logic [DATA_WIDTH-1:0] w_right;
        logic [DATA_WIDTH-1:0] w_bus_in;

        if (g == 0) begin : g_first
            assign w_left = '0;
        end else begin : g_mid
            assign w_left = w_data[g-1];
        end

        if (g == DEPTH - 1) begin : g_last
            assign w_right  = '0;
            assign w_bus_in = '0;
        end else begin : g_body
            assign w_right  = w_data[g+1];
            assign w_bus_in = w_bus[g+1];
        end

        iiea_cell #(
            .DATA_WIDTH (DATA_WIDTH)
        ) u_cell (
            .i_clk   (i_clk),
            .i_ctl   (w_ctl[g]),
            .i_val   (w_val),
            .i_left  (w_left),
            .i_right (w_right),
            .i_bus   (w_bus_in),
            .o_data  (w_data[g]),
            .o_bus   (w_bus[g])
        );
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = w_read_ok ? S_WAIT : S_OUT;
                end
            end
            S_WAIT: begin
                if (r_hop == '0) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (w_accept) begin
                    n_state = w_read_ok ? S_WAIT : S_OUT;
                end else if (w_out_take) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // register updates
    always_comb begin
        n_hop    = r_hop;
        n_rd     = r_rd;
        n_status = r_status;
        case (r_state)
            S_WAIT: begin
                n_hop = r_hop - IW'(1);
                if (r_hop == '0) begin
                    n_rd = w_bus_ext[31:0];
                end
            end
            S_IDLE, S_OUT: begin
                if (w_accept) begin
                    n_hop    = w_pos[IW-1:0];
                    n_rd     = '0;
                    n_status = w_status;
                end
            end
            default: begin
                n_hop = r_hop;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            if (w_accept) begin
                r_count <= n_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_hop    <= n_hop;
        r_rd     <= n_rd;
        r_status <= n_status;
    end

    assign m_axis_tvalid = (r_state == S_OUT);
    assign m_axis_tdata  = {7'd0, r_status, 7'(r_count), r_rd};

    // checks
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("entry count beyond capacity");

    a_full_means_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (r_status == ST_FULL)) |-> (r_count == CW'(DEPTH)))
        else $error("full status with room left");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_accept |=> (r_count == $past(r_count)))
        else $error("count changed without a command");

    a_read_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WAIT) |-> (r_status == ST_OK))
        else $error("read in flight with failing status");

endmodule

// File: sim/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for indexed_insert_erase_array_core. A directed table
// covers empty and out-of-range commands, insert at the end, extreme values and
// the unused command codes. Random phases then grow the array to full and
// shrink it to empty, with reads and noise mixed in. Results of typed rows are
// checked against the table, all others against a behavioural array kept in
// step with accepted commands. Both stream sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import iiea_pkg::*;

    localparam int ARRAY_DEPTH  = 64;
    localparam int RANDOM_ITEMS = 500;
    localparam int QUIET_TAIL   = 80;
    localparam int DRAIN_CYCLES = ARRAY_DEPTH + 8;
    localparam int LIMIT_CYCLES = 400000;
    localparam int N_DIR        = 25;

    localparam logic [2:0] CMD_SPARE_5 = 3'd5;
    localparam logic [2:0] CMD_SPARE_6 = 3'd6;
    localparam logic [2:0] CMD_SPARE_7 = 3'd7;

    typedef enum int {PH_GROW, PH_SHRINK, PH_MIXED} t_phase;

    typedef struct packed {
        logic [31:0] read_value;
        logic [6:0]  count;
        t_status     status;
    } t_result;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [6:0]  pos;
        logic [31:0] val;
        logic        typed;
        logic [31:0] rd;
        logic [6:0]  cnt;
        t_status     st;
    } t_stim_row;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    // command[2:0], position[9:3], item_value[41:10], zero pad
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    // read_value[31:0], count[38:32], status[40:39], zero pad
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    logic [31:0] array_slots [ARRAY_DEPTH];
    int          array_count = 0;
    t_result     pending_results [$];
    t_result     head_result;

    bit idle_on = 1'b1;
    int stall_left = 0;
    int mismatches = 0;
    int cycles = 0;
    int n_words = 0;
    int n_full = 0;
    int n_range = 0;
    int n_read_hits = 0;
    int peak_count = 0;

    t_stim_row dir_rows [N_DIR] = '{
        '{CMD_POP,     7'd0,   32'd0,         1'b1, 32'd0,         7'd0, ST_RANGE},
        '{CMD_READ,    7'd0,   32'd0,         1'b1, 32'd0,         7'd0, ST_RANGE},
        '{CMD_ERASE,   7'd0,   32'd0,         1'b1, 32'd0,         7'd0, ST_RANGE},
        '{CMD_INSERT,  7'd1,   32'd5,         1'b1, 32'd0,         7'd0, ST_RANGE},
        '{CMD_INSERT,  7'd0,   32'h8000_0000, 1'b1, 32'd0,         7'd1, ST_OK},
        '{CMD_PUSH,    7'd0,   32'h7fff_ffff, 1'b1, 32'd0,         7'd2, ST_OK},
        '{CMD_PUSH,    7'd0,   32'hffff_ffff, 1'b1, 32'd0,         7'd3, ST_OK},
        '{CMD_INSERT,  7'd3,   32'd0,         1'b1, 32'd0,         7'd4, ST_OK},
        '{CMD_INSERT,  7'd1,   32'h1234_5678, 1'b0, 32'd0,         7'd0, ST_OK},
        '{CMD_READ,    7'd0,   32'd0,         1'b1, 32'h8000_0000, 7'd5, ST_OK},
        '{CMD_READ,    7'd2,   32'd0,         1'b0, 32'd0,         7'd0, ST_OK},
        '{CMD_READ,    7'd4,   32'd0,         1'b0, 32'd0,         7'd0, ST_OK},
        '{CMD_READ,    7'd5,   32'd0,         1'b1, 32'd0,         7'd5, ST_RANGE},
        '{CMD_READ,    7'd127, 32'd0,         1'b1, 32'd0,         7'd5, ST_RANGE},
        '{CMD_ERASE,   7'd127, 32'd0,         1'b1, 32'd0,         7'd5, ST_RANGE},
        '{CMD_INSERT,  7'd127, 32'hffff_ffff, 1'b1, 32'd0,         7'd5, ST_RANGE},
        '{CMD_ERASE,   7'd0,   32'd0,         1'b0, 32'd0,         7'd0, ST_OK},
        '{CMD_SPARE_5, 7'd0,   32'd0,         1'b1, 32'd0,         7'd4, ST_OK},
        '{CMD_SPARE_6, 7'd127, 32'hffff_ffff, 1'b1, 32'd0,         7'd4, ST_OK},
        '{CMD_SPARE_7, 7'd64,  32'h5555_aaaa, 1'b1, 32'd0,         7'd4, ST_OK},
        '{CMD_POP,     7'd0,   32'd0,         1'b0, 32'd0,         7'd0, ST_OK},
        '{CMD_READ,    7'd2,   32'd0,         1'b0, 32'd0,         7'd0, ST_OK},
        '{CMD_ERASE,   7'd2,   32'd0,         1'b0, 32'd0,         7'd0, ST_OK},
        '{CMD_READ,    7'd1,   32'd0,         1'b0, 32'd0,         7'd0, ST_OK},
        '{CMD_PUSH,    7'd0,   32'h5a5a_5a5a, 1'b0, 32'd0,         7'd0, ST_OK}
    };

    indexed_insert_erase_array_core #(
        .DEPTH      (ARRAY_DEPTH),
        .DATA_WIDTH (32)
    ) DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > LIMIT_CYCLES) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // applies one command to the behavioural array, returns the result word
    function automatic t_result apply_command(input logic [2:0] cmd, input logic [6:0] pos,
                                              input logic [31:0] val);
        t_result r;
        int      i;
        r.read_value = '0;
        r.status     = ST_OK;
        case (cmd)
            CMD_PUSH: begin
                if (array_count >= ARRAY_DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    array_slots[array_count] = val;
                    array_count++;
                end
            end
            CMD_POP: begin
                if (array_count == 0) begin
                    r.status = ST_RANGE;
                end else begin
                    array_count--;
                end
            end
            CMD_INSERT: begin
                if (int'(pos) > array_count) begin
                    r.status = ST_RANGE;
                end else if (array_count >= ARRAY_DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    for (i = array_count; i > int'(pos); i--)
                        array_slots[i] = array_slots[i-1];
                    array_slots[pos] = val;
                    array_count++;
                end
            end
            CMD_ERASE: begin
                if (int'(pos) >= array_count) begin
                    r.status = ST_RANGE;
                end else begin
                    for (i = int'(pos); i + 1 < array_count; i++)
                        array_slots[i] = array_slots[i+1];
                    array_count--;
                end
            end
            CMD_READ: begin
                if (int'(pos) >= array_count)
                    r.status = ST_RANGE;
                else
                    r.read_value = array_slots[pos];
            end
            default: ;
        endcase
        r.count = array_count[6:0];
        return r;
    endfunction

    task automatic send_command(input logic [2:0] cmd, input logic [6:0] pos,
                                input logic [31:0] val, input logic typed,
                                input t_result typed_res);
        t_result predicted;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {6'd0, val, pos, cmd};
        do @(posedge i_clk); while (!s_axis_tready);
        predicted = apply_command(cmd, pos, val);
        pending_results.insert(pending_results.size(), typed ? typed_res : predicted);
        n_words++;
        if (predicted.status == ST_FULL) n_full++;
        if (predicted.status == ST_RANGE) n_range++;
        if (cmd == CMD_READ && predicted.status == ST_OK) n_read_hits++;
        if (array_count > peak_count) peak_count = array_count;
    endtask

    function automatic logic [31:0] pick_value();
        logic [31:0] v;
        case ($urandom_range(0, 11))
            0:       v = 32'h8000_0000;
            1:       v = 32'h7fff_ffff;
            2:       v = 32'h0000_0000;
            3:       v = 32'hffff_ffff;
            default: v = $urandom;
        endcase
        return v;
    endfunction

    // mostly in range for the current fill, sometimes anywhere in the field
    function automatic logic [6:0] pick_position(input logic [2:0] cmd);
        int p;
        if ($urandom_range(0, 9) == 0)
            p = $urandom_range(0, 127);
        else if (cmd == CMD_INSERT)
            p = $urandom_range(0, array_count);
        else if (array_count > 0)
            p = $urandom_range(0, array_count - 1);
        else
            p = $urandom_range(0, 127);
        return p[6:0];
    endfunction

    function automatic logic [2:0] pick_command(input t_phase ph);
        int         r;
        logic [2:0] c;
        r = $urandom_range(0, 99);
        if (r < 5) begin
            c = 3'($urandom_range(CMD_SPARE_5, CMD_SPARE_7));
        end else if (ph == PH_GROW) begin
            c = (r < 45) ? CMD_PUSH : (r < 75) ? CMD_INSERT : (r < 87) ? CMD_READ :
                (r < 94) ? CMD_ERASE : CMD_POP;
        end else if (ph == PH_SHRINK) begin
            c = (r < 35) ? CMD_POP : (r < 70) ? CMD_ERASE : (r < 86) ? CMD_READ :
                (r < 94) ? CMD_PUSH : CMD_INSERT;
        end else begin
            c = (r < 24) ? CMD_PUSH : (r < 43) ? CMD_POP : (r < 62) ? CMD_INSERT :
                (r < 81) ? CMD_ERASE : CMD_READ;
        end
        return c;
    endfunction

    // result side: check words, stall in bursts
    always @(posedge i_clk) begin
        if (m_axis_tvalid && m_axis_tready) begin
            if (pending_results.size() == 0) begin
                $error("result word with nothing pending: %h", m_axis_tdata);
                mismatches++;
            end else begin
                head_result = pending_results.pop_front();
                if (m_axis_tdata[31:0] !== head_result.read_value) begin
                    $error("read_value expected %h got %h", head_result.read_value,
                           m_axis_tdata[31:0]);
                    mismatches++;
                end
                if (m_axis_tdata[38:32] !== head_result.count) begin
                    $error("count expected %0d got %0d", head_result.count,
                           m_axis_tdata[38:32]);
                    mismatches++;
                end
                if (m_axis_tdata[40:39] !== head_result.status) begin
                    $error("status expected %0d got %0d", head_result.status,
                           m_axis_tdata[40:39]);
                    mismatches++;
                end
            end
        end
        if (stall_left > 0) begin
            stall_left    <= stall_left - 1;
            m_axis_tready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 4) == 0) begin
            stall_left    <= $urandom_range(0, 6);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    initial begin
        t_phase     ph;
        int         sent;
        int         tail;
        int         span;
        int         k;
        logic [2:0] c;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (k = 0; k < N_DIR; k++)
            send_command(dir_rows[k].cmd, dir_rows[k].pos, dir_rows[k].val, dir_rows[k].typed,
                         t_result'{dir_rows[k].rd, dir_rows[k].cnt, dir_rows[k].st});

        // grow first so that full is reached early, then phases at random
        sent = 0;
        ph   = PH_GROW;
        while (sent < RANDOM_ITEMS) begin
            idle_on = (sent < RANDOM_ITEMS - QUIET_TAIL) && ($urandom_range(0, 3) != 0);
            tail    = $urandom_range(4, 8);
            span    = 0;
            while (tail > 0 && span < 160 && sent < RANDOM_ITEMS) begin
                c = pick_command(ph);
                send_command(c, pick_position(c), pick_value(), 1'b0, '0);
                if (c <= CMD_READ) sent++;
                span++;
                if (ph == PH_MIXED && span >= 40) tail = 0;
                if ((ph == PH_GROW && array_count == ARRAY_DEPTH) ||
                    (ph == PH_SHRINK && array_count == 0))
                    tail--;
                if (sent >= RANDOM_ITEMS - QUIET_TAIL) idle_on = 1'b0;
            end
            ph = t_phase'($urandom_range(0, 2));
        end
        s_axis_tvalid <= 1'b0;
        idle_on = 1'b0;

        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("%0d command words, %0d successful reads, peak fill %0d of %0d",
                 n_words, n_read_hits, peak_count, ARRAY_DEPTH);
        $display("%0d full refusals, %0d range or empty refusals", n_full, n_range);
        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// File: sim.f
hdl/iiea_pkg.sv
hdl/iiea_cell.sv
hdl/indexed_insert_erase_array_core.sv
sim/tb.sv
